// ===== hdl/rv32dia_pkg.sv =====
// Package for the RV32I subset decode/ALU block: opcodes, ALU and branch codes,
// and the input and result transaction structs.
// No dependencies.
`default_nettype none

package rv32dia_pkg;

  localparam logic [6:0] OP_R      = 7'b0110011;
  localparam logic [6:0] OP_I      = 7'b0010011;
  localparam logic [6:0] OP_LOAD   = 7'b0000011;
  localparam logic [6:0] OP_JALR   = 7'b1100111;
  localparam logic [6:0] OP_STORE  = 7'b0100011;
  localparam logic [6:0] OP_BRANCH = 7'b1100011;
  localparam logic [6:0] OP_JAL    = 7'b1101111;

  localparam logic [6:0] F7_ADD = 7'b0000000;
  localparam logic [6:0] F7_SUB = 7'b0100000;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SRL  = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  localparam logic [2:0] F3_BEQ = 3'd0;
  localparam logic [2:0] F3_BNE = 3'd1;
  localparam logic [2:0] F3_BLT = 3'd4;
  localparam logic [2:0] F3_BGE = 3'd5;

  localparam logic [2:0] FN_AND = 3'd0;
  localparam logic [2:0] FN_OR  = 3'd1;
  localparam logic [2:0] FN_ADD = 3'd2;
  localparam logic [2:0] FN_SLL = 3'd3;
  localparam logic [2:0] FN_SRL = 3'd4;
  localparam logic [2:0] FN_XOR = 3'd5;
  localparam logic [2:0] FN_SUB = 3'd6;
  localparam logic [2:0] FN_SLT = 3'd7;

  localparam logic [2:0] BK_NONE = 3'd0;
  localparam logic [2:0] BK_BEQ  = 3'd1;
  localparam logic [2:0] BK_BNE  = 3'd2;
  localparam logic [2:0] BK_BLT  = 3'd3;
  localparam logic [2:0] BK_BGE  = 3'd4;

  typedef struct packed {
    logic        [31:0] instruction;
    logic signed [31:0] rs1_value;
    logic signed [31:0] rs2_value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] alu_result;
    logic               equal_flag;
    logic signed [31:0] immediate;
    logic               writes_rd;
    logic               mem_read;
    logic               mem_write;
    logic               mem_to_reg;
    logic               alu_src;
    logic               jump;
    logic        [2:0]  branch_kind;
    logic        [2:0]  alu_function;
    logic               unsupported;
  } out_t;

endpackage

`default_nettype wire

// ===== hdl/rv32_decode_immediate_alu.sv =====
// RV32I subset decode, immediate generation and ALU, registered in and out.
// Depends on rv32dia_pkg.
//
//   channel | ports                          | transfer
//   input   | start, busy, in_item           | start && !busy at rising clk
//   result  | out_valid, out_item            | out_valid high for one cycle
//
// One transaction per cycle; busy is always low.
// Pipeline: input register, then decode + ALU into the result register.
// Synchronous active-low reset clears the valid bits only.
// The receiver cannot stall, so no backpressure path exists.
`default_nettype none

module rv32_decode_immediate_alu (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    start,
  output logic                   busy,
  input  wire rv32dia_pkg::in_t  in_item,
  output logic                   out_valid,
  output rv32dia_pkg::out_t      out_item
);

  logic              in_valid_r;
  rv32dia_pkg::in_t  in_r;
  logic              out_valid_r;
  rv32dia_pkg::out_t out_r;
  rv32dia_pkg::out_t out_nxt;

  logic [31:0] w;
  logic [6:0]  op;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [31:0] imm;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [31:0] alu;
  logic        rw, mr, mw, m2r, src, jmp, bad;
  logic [2:0]  bk;
  logic [2:0]  fn;

  assign busy      = 1'b0;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= start && !busy;
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_r <= in_item;
    end
    if (in_valid_r) begin
      out_r <= out_nxt;
    end
  end

  assign w  = in_r.instruction;
  assign op = w[6:0];
  assign f3 = w[14:12];
  assign f7 = w[31:25];

  always_comb begin
    rw  = 1'b0;
    mr  = 1'b0;
    mw  = 1'b0;
    m2r = 1'b0;
    src = 1'b0;
    jmp = 1'b0;
    bad = 1'b0;
    bk  = rv32dia_pkg::BK_NONE;
    fn  = rv32dia_pkg::FN_ADD;
    imm = 32'd0;
    unique case (op)
      rv32dia_pkg::OP_R, rv32dia_pkg::OP_I: begin
        rw  = 1'b1;
        src = (op == rv32dia_pkg::OP_I);
        if (op == rv32dia_pkg::OP_I) begin
          imm = {{20{w[31]}}, w[31:20]};
        end
        unique case (f3)
          rv32dia_pkg::F3_ADD: begin
            if (op == rv32dia_pkg::OP_R) begin
              if (f7 == rv32dia_pkg::F7_SUB) begin
                fn = rv32dia_pkg::FN_SUB;
              end else if (f7 != rv32dia_pkg::F7_ADD) begin
                bad = 1'b1;
              end
            end
          end
          rv32dia_pkg::F3_SLL:  fn  = rv32dia_pkg::FN_SLL;
          rv32dia_pkg::F3_SLT:  fn  = rv32dia_pkg::FN_SLT;
          rv32dia_pkg::F3_SLTU: bad = 1'b1;
          rv32dia_pkg::F3_XOR:  fn  = rv32dia_pkg::FN_XOR;
          rv32dia_pkg::F3_SRL:  fn  = rv32dia_pkg::FN_SRL;
          rv32dia_pkg::F3_OR:   fn  = rv32dia_pkg::FN_OR;
          rv32dia_pkg::F3_AND:  fn  = rv32dia_pkg::FN_AND;
        endcase
      end
      rv32dia_pkg::OP_LOAD: begin
        rw  = 1'b1;
        src = 1'b1;
        mr  = 1'b1;
        m2r = 1'b1;
        imm = {{20{w[31]}}, w[31:20]};
      end
      rv32dia_pkg::OP_JALR: begin
        rw  = 1'b1;
        src = 1'b1;
        jmp = 1'b1;
        imm = {{20{w[31]}}, w[31:20]};
      end
      rv32dia_pkg::OP_STORE: begin
        src = 1'b1;
        mw  = 1'b1;
        imm = {{20{w[31]}}, w[31:25], w[11:7]};
      end
      rv32dia_pkg::OP_BRANCH: begin
        imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        unique case (f3)
          rv32dia_pkg::F3_BEQ: begin
            bk = rv32dia_pkg::BK_BEQ;
            fn = rv32dia_pkg::FN_SUB;
          end
          rv32dia_pkg::F3_BNE: begin
            bk = rv32dia_pkg::BK_BNE;
            fn = rv32dia_pkg::FN_SUB;
          end
          rv32dia_pkg::F3_BLT: begin
            bk = rv32dia_pkg::BK_BLT;
            fn = rv32dia_pkg::FN_SLT;
          end
          rv32dia_pkg::F3_BGE: begin
            bk = rv32dia_pkg::BK_BGE;
            fn = rv32dia_pkg::FN_SLT;
          end
          default: bad = 1'b1;
        endcase
      end
      rv32dia_pkg::OP_JAL: begin
        rw  = 1'b1;
        jmp = 1'b1;
        imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
      end
      default: bad = 1'b1;
    endcase
  end

  assign op_a = in_r.rs1_value;
  assign op_b = src ? imm : in_r.rs2_value;

  always_comb begin
    unique case (fn)
      rv32dia_pkg::FN_AND: alu = op_a & op_b;
      rv32dia_pkg::FN_OR:  alu = op_a | op_b;
      rv32dia_pkg::FN_ADD: alu = op_a + op_b;
      rv32dia_pkg::FN_SLL: alu = op_a << op_b[4:0];
      rv32dia_pkg::FN_SRL: alu = op_a >> op_b[4:0];
      rv32dia_pkg::FN_XOR: alu = op_a ^ op_b;
      rv32dia_pkg::FN_SUB: alu = op_a - op_b;
      rv32dia_pkg::FN_SLT: alu = {31'd0, ($signed(op_a) < $signed(op_b))};
    endcase
  end

  always_comb begin
    out_nxt.alu_result   = alu;
    out_nxt.equal_flag   = (op_a == op_b);
    out_nxt.immediate    = imm;
    out_nxt.writes_rd    = rw;
    out_nxt.mem_read     = mr;
    out_nxt.mem_write    = mw;
    out_nxt.mem_to_reg   = m2r;
    out_nxt.alu_src      = src;
    out_nxt.jump         = jmp;
    out_nxt.branch_kind  = bk;
    out_nxt.alu_function = fn;
    out_nxt.unsupported  = bad;
  end

`ifndef SYNTH
  a_strobe_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("result strobe missing two cycles after accept");

  a_jump_writes_reg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.jump) |-> (out_item.writes_rd && !out_item.mem_write))
    else $error("jump without register write");

  a_branch_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.branch_kind != rv32dia_pkg::BK_NONE) |->
      (!out_item.writes_rd && !out_item.unsupported && !out_item.alu_src))
    else $error("branch with write, source or unsupported flag");

  a_load_controls: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.mem_read) |-> (out_item.alu_src && out_item.mem_to_reg
      && out_item.alu_function == rv32dia_pkg::FN_ADD))
    else $error("load control mismatch");

  a_unsupported_adds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.unsupported) |->
      (out_item.alu_function == rv32dia_pkg::FN_ADD))
    else $error("unsupported encoding must select add");
`endif

endmodule

`default_nettype wire

// ===== tb/rv32dia_tb_pkg.sv =====
// Scoreboard for the RV32I subset decode/ALU block: predicts each decode and
// checks the results in order. Depends on rv32dia_pkg.
package rv32dia_tb_pkg;

  import rv32dia_pkg::*;

  class decode_scoreboard;

    out_t pending_decodes[$];
    int   mismatch_count = 0;

    function automatic out_t decode_execute(in_t x);
      out_t        r;
      logic [31:0] w;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] imm;
      logic [6:0]  op;
      logic [6:0]  f7;
      logic [2:0]  f3;
      w  = x.instruction;
      a  = x.rs1_value;
      op = w[6:0];
      f3 = w[14:12];
      f7 = w[31:25];
      r = '0;
      r.alu_function = FN_ADD;
      case (op)
        OP_R, OP_I: begin
          r.writes_rd = 1'b1;
          r.alu_src   = (op == OP_I);
          case (f3)
            F3_ADD: begin
              if (op == OP_I || f7 == F7_ADD) r.alu_function = FN_ADD;
              else if (f7 == F7_SUB) r.alu_function = FN_SUB;
              else r.unsupported = 1'b1;
            end
            F3_SLL:  r.alu_function = FN_SLL;
            F3_SLT:  r.alu_function = FN_SLT;
            F3_SLTU: r.unsupported  = 1'b1;
            F3_XOR:  r.alu_function = FN_XOR;
            F3_SRL:  r.alu_function = FN_SRL;
            F3_OR:   r.alu_function = FN_OR;
            default: r.alu_function = FN_AND;
          endcase
        end
        OP_LOAD: begin
          r.writes_rd  = 1'b1;
          r.alu_src    = 1'b1;
          r.mem_read   = 1'b1;
          r.mem_to_reg = 1'b1;
        end
        OP_JALR: begin
          r.writes_rd = 1'b1;
          r.alu_src   = 1'b1;
          r.jump      = 1'b1;
        end
        OP_STORE: begin
          r.alu_src   = 1'b1;
          r.mem_write = 1'b1;
        end
        OP_BRANCH: begin
          case (f3)
            F3_BEQ: begin
              r.branch_kind  = BK_BEQ;
              r.alu_function = FN_SUB;
            end
            F3_BNE: begin
              r.branch_kind  = BK_BNE;
              r.alu_function = FN_SUB;
            end
            F3_BLT: begin
              r.branch_kind  = BK_BLT;
              r.alu_function = FN_SLT;
            end
            F3_BGE: begin
              r.branch_kind  = BK_BGE;
              r.alu_function = FN_SLT;
            end
            default: r.unsupported = 1'b1;
          endcase
        end
        OP_JAL: begin
          r.writes_rd = 1'b1;
          r.jump      = 1'b1;
        end
        default: r.unsupported = 1'b1;
      endcase

      case (op)
        OP_I, OP_LOAD, OP_JALR: imm = {{20{w[31]}}, w[31:20]};
        OP_STORE:  imm = {{20{w[31]}}, w[31:25], w[11:7]};
        OP_BRANCH: imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        OP_JAL:    imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        default:   imm = '0;
      endcase
      r.immediate = imm;

      b = r.alu_src ? imm : x.rs2_value;
      case (r.alu_function)
        FN_AND:  r.alu_result = a & b;
        FN_OR:   r.alu_result = a | b;
        FN_ADD:  r.alu_result = a + b;
        FN_SLL:  r.alu_result = a << b[4:0];
        FN_SRL:  r.alu_result = a >> b[4:0];
        FN_XOR:  r.alu_result = a ^ b;
        FN_SUB:  r.alu_result = a - b;
        default: r.alu_result = {31'b0, $signed(a) < $signed(b)};
      endcase
      r.equal_flag = (a == b);
      return r;
    endfunction

    task automatic report(string msg);
      $display("ERROR %0t: %s", $time, msg);
      mismatch_count++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("%s got %h expected %h", name, got, want));
    endtask

    function automatic void note_instruction(in_t x);
      pending_decodes.push_back(decode_execute(x));
    endfunction

    task automatic check_result(out_t got);
      out_t want;
      if (pending_decodes.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      want = pending_decodes.pop_front();
      check_field("alu_result", got.alu_result, want.alu_result);
      check_field("equal_flag", got.equal_flag, want.equal_flag);
      check_field("immediate", got.immediate, want.immediate);
      check_field("writes_rd", got.writes_rd, want.writes_rd);
      check_field("mem_read", got.mem_read, want.mem_read);
      check_field("mem_write", got.mem_write, want.mem_write);
      check_field("mem_to_reg", got.mem_to_reg, want.mem_to_reg);
      check_field("alu_src", got.alu_src, want.alu_src);
      check_field("jump", got.jump, want.jump);
      check_field("branch_kind", got.branch_kind, want.branch_kind);
      check_field("alu_function", got.alu_function, want.alu_function);
      check_field("unsupported", got.unsupported, want.unsupported);
    endtask

    task automatic check_drained();
      if (pending_decodes.size() != 0)
        report($sformatf("%0d results never arrived", pending_decodes.size()));
    endtask

  endclass

endpackage

// ===== tb/tb_rv32_decode_immediate_alu.sv =====
// Top-level testbench for rv32_decode_immediate_alu: directed and random
// instructions with bursty input timing, checked by decode_scoreboard.
// Depends on rv32dia_pkg and rv32dia_tb_pkg.
module tb_rv32_decode_immediate_alu;

  timeunit 1ns;
  timeprecision 1ps;

  import rv32dia_pkg::*;
  import rv32dia_tb_pkg::*;

  localparam int NUM_RANDOM  = 1850;
  localparam int IDLE_LIMIT  = 1000;
  localparam int DRAIN_TAIL  = 4;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_item;
  logic out_valid;
  out_t out_item;

  decode_scoreboard sb = new();
  int burst_left = 0;
  int idle_cycles = 0;

  rv32_decode_immediate_alu DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_item);
      if (start && !busy) sb.note_instruction(in_item);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("rv32_decode_immediate_alu test failed");
      $finish;
    end
  end

  function automatic logic [31:0] build_instr(logic [6:0] op, logic [2:0] f3,
                                              logic [6:0] f7);
    logic [31:0] w;
    w = $urandom;
    return {f7, w[24:15], f3, w[11:7], op};
  endfunction

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0:       return 32'h0;
      1:       return 32'h7fff_ffff;
      2:       return 32'h8000_0000;
      3:       return 32'hffff_ffff;
      4:       return $urandom_range(0, 40);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(in_t x);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    start   <= 1'b1;
    in_item <= x;
    do @(posedge clk); while (busy);
  endtask

  task automatic send(logic [31:0] w, logic [31:0] a, logic [31:0] b);
    in_t x;
    x.instruction = w;
    x.rs1_value   = a;
    x.rs2_value   = b;
    send_item(x);
  endtask

  task automatic send_random();
    in_t        x;
    out_t       p;
    logic [6:0] op;
    logic [2:0] f3;
    logic [6:0] f7;
    x.instruction = $urandom;
    if ($urandom_range(0, 9) != 0) begin
      case ($urandom_range(0, 6))
        0:       op = OP_R;
        1:       op = OP_I;
        2:       op = OP_LOAD;
        3:       op = OP_JALR;
        4:       op = OP_STORE;
        5:       op = OP_BRANCH;
        default: op = OP_JAL;
      endcase
      f3 = 3'($urandom);
      f7 = x.instruction[31:25];
      if (op == OP_BRANCH && $urandom_range(0, 7) != 0) begin
        case ($urandom_range(0, 3))
          0:       f3 = F3_BEQ;
          1:       f3 = F3_BNE;
          2:       f3 = F3_BLT;
          default: f3 = F3_BGE;
        endcase
      end
      if (op == OP_R && $urandom_range(0, 7) != 0)
        f7 = $urandom_range(0, 1) ? F7_SUB : F7_ADD;
      x.instruction = {f7, x.instruction[24:15], f3, x.instruction[11:7], op};
    end
    x.rs1_value = pick_operand();
    x.rs2_value = pick_operand();
    if ($urandom_range(0, 7) == 0) x.rs2_value = x.rs1_value;
    if ($urandom_range(0, 7) == 0) begin
      p = sb.decode_execute(x);
      x.rs1_value = p.immediate;
    end
    send_item(x);
  endtask

  initial begin
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_item <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // R-type: every function, wrap, logical shift right, bad funct7
    send(build_instr(OP_R, F3_ADD, F7_ADD), 32'h7fff_ffff, 32'h1);
    send(build_instr(OP_R, F3_ADD, F7_SUB), 32'h8000_0000, 32'h1);
    send(build_instr(OP_R, F3_SLL, F7_ADD), 32'h1, 32'hffff_ffff);
    send(build_instr(OP_R, F3_SLT, F7_ADD), 32'h8000_0000, 32'h7fff_ffff);
    send(build_instr(OP_R, F3_SLTU, F7_ADD), 32'h5, 32'h5);
    send(build_instr(OP_R, F3_XOR, F7_ADD), 32'hffff_ffff, 32'h0);
    send(build_instr(OP_R, F3_SRL, F7_SUB), 32'h8000_0000, 32'h3f);
    send(build_instr(OP_R, F3_OR, F7_ADD), 32'h0, 32'h0);
    send(build_instr(OP_R, F3_AND, F7_ADD), 32'hffff_ffff, 32'h8000_0001);
    send(build_instr(OP_R, F3_ADD, 7'h01), 32'h3, 32'h4);
    // I-type: addi ignores funct7 bits, slti, sltiu unsupported, srli
    send(build_instr(OP_I, F3_ADD, 7'h7f), 32'h0, 32'h1234);
    send(build_instr(OP_I, F3_SLT, 7'h40), 32'h8000_0000, 32'h0);
    send(build_instr(OP_I, F3_SLTU, 7'h00), 32'h1, 32'h1);
    send(build_instr(OP_I, F3_SRL, F7_SUB), 32'hffff_ffff, 32'h0);
    // memory and jumps, immediate extremes
    send({12'h7ff, 5'd1, 3'd2, 5'd3, OP_LOAD}, 32'h7fff_ffff, 32'h0);
    send({7'h40, 5'd2, 5'd1, 3'd2, 5'd0, OP_STORE}, 32'h0, 32'hffff_ffff);
    send({25'h1ff_ffff, OP_JAL}, 32'h8000_0000, 32'h8000_0000);
    send({25'h0ff_ffff, OP_JAL}, 32'h1, 32'h2);
    send(build_instr(OP_JALR, 3'd7, 7'h7f), 32'hffff_ffff, 32'h0);
    // branches, including two of the unsupported funct3 values
    send(build_instr(OP_BRANCH, F3_BEQ, 7'h7f), 32'h1234_5678, 32'h1234_5678);
    send(build_instr(OP_BRANCH, F3_BNE, 7'h00), 32'h0, 32'h1);
    send(build_instr(OP_BRANCH, F3_BLT, 7'h3f), 32'hffff_ffff, 32'h0);
    send(build_instr(OP_BRANCH, F3_BGE, 7'h40), 32'h7fff_ffff, 32'h8000_0000);
    send(build_instr(OP_BRANCH, 3'd2, 7'h00), 32'h1, 32'h1);
    send(build_instr(OP_BRANCH, 3'd7, 7'h7f), 32'h2, 32'h1);
    // unknown opcodes
    send(32'hffff_ffff, 32'h7fff_ffff, 32'h1);
    send(32'h0, 32'h0, 32'h0);

    repeat (NUM_RANDOM) send_random();

    start <= 1'b0;
    while (sb.pending_decodes.size() > 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
    sb.check_drained();
    if (sb.mismatch_count == 0) begin
      $display("rv32_decode_immediate_alu test passed");
    end else begin
      $display("rv32_decode_immediate_alu test failed");
    end
    $finish;
  end

endmodule
